FILE: design/mdio_ms_pkg.sv
`timescale 1ns / 1ps

package mdio_ms_pkg;

  // Frame decoder modes, kept in a plain vector.
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_READING = 2'd1;
  localparam logic [1:0] MODE_WRITING = 2'd2;

  // Clause 22 frame field codes.
  localparam logic [1:0] START_CODE = 2'b01;
  localparam logic [1:0] OPC_WRITE  = 2'b01;
  localparam logic [1:0] OPC_READ   = 2'b10;
  localparam logic [1:0] TA_WRITE   = 2'b10;

  // Bit counter landmarks; the counter runs signed from 32 down to -1.
  localparam int unsigned CntW = 7;
  localparam logic signed [CntW-1:0] CNT_RESYNC = 7'sd32;
  localparam logic signed [CntW-1:0] CNT_DECODE = 7'sd16;
  localparam logic signed [CntW-1:0] CNT_LAST   = 7'sd0;
  localparam logic signed [CntW-1:0] CNT_STOP   = -7'sd1;

  // Register map.
  localparam logic [4:0] REG_ID_HIGH = 5'd2;
  localparam logic [4:0] REG_ID_LOW  = 5'd3;

  // Configuration register indexes and reset values.
  localparam logic CFG_PHY_ID_HIGH = 1'b0;
  localparam logic CFG_PHY_ID_LOW  = 1'b1;
  localparam logic [15:0] PHY_ID_HIGH_RST = 16'h0022;
  localparam logic [15:0] PHY_ID_LOW_RST  = 16'h161a;

  // One result of the slave for one line sample.
  typedef struct packed {
    logic        mdi_level;
    logic        write_done;
    logic [4:0]  write_phy;
    logic [4:0]  write_reg;
    logic [15:0] write_data;
  } mdio_ms_result_t;

endpackage

FILE: design/mdio_management_slave.sv
`timescale 1ns / 1ps

// MDIO clause 22 management slave, PHY side, fed with sampled line levels.
// Input channel: one transfer carries one sample of mdc, mdo and mdo_enable.
// Output channel: one transfer per input sample, giving the data-in level the
// slave drives and, on the sample that ends a write frame, the write's PHY
// address, register address and data (zero otherwise).
// Configuration: a write enable, a one-bit register index (0 for the high ID
// word, 1 for the low ID word) and 16 bits of data; write only while idle.
// From input transfer to output valid, the sample first lands in the input
// register, and the frame logic then runs from it into the result register.
// Throughput is one sample per cycle while the receiver does not stall; the
// input register takes a new sample while the result register holds a
// finished one that is stalled.
// When the receiver stalls, the result holds, the input register fills, and
// in_stall_o rises only once both are occupied.
// Reset clears the frame state, both valids and returns the ID words to their
// defaults.
module mdio_management_slave (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mdc_i,
  input  logic        mdo_i,
  input  logic        mdo_enable_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        mdi_level_o,
  output logic        write_done_o,
  output logic [4:0]  write_phy_o,
  output logic [4:0]  write_reg_o,
  output logic [15:0] write_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mdio_ms_pkg::*;

  logic            in_valid_q;
  logic            mdc_q, mdo_q, mdo_en_q;
  logic            out_valid_q;
  mdio_ms_result_t res_d, res_q;
  logic            advance, in_take;
  logic [4:0]      rd_addr;
  logic [15:0]     rd_data;

  // A sample moves on when the result register is free or being emptied.
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mdc_q    <= mdc_i;
      mdo_q    <= mdo_i;
      mdo_en_q <= mdo_enable_i;
    end
  end

  mdio_ms_id_regs u_id_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  mdio_ms_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .mdc_i        (mdc_q),
    .mdo_i        (mdo_q),
    .mdo_enable_i (mdo_en_q),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .result_o     (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mdi_level_o  = res_q.mdi_level;
  assign write_done_o = res_q.write_done;
  assign write_phy_o  = res_q.write_phy;
  assign write_reg_o  = res_q.write_reg;
  assign write_data_o = res_q.write_data;

endmodule

FILE: design/mdio_ms_id_regs.sv
`timescale 1ns / 1ps

module mdio_ms_id_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [4:0]  rd_addr_i,
  output logic [15:0] rd_data_o
);
  import mdio_ms_pkg::*;

  logic [15:0] id_high_q;
  logic [15:0] id_low_q;

  // Identifier registers, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_high_q <= PHY_ID_HIGH_RST;
      id_low_q  <= PHY_ID_LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PHY_ID_HIGH: id_high_q <= cfg_data_i;
        CFG_PHY_ID_LOW:  id_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Register map: only the two identifier words read nonzero.
  always_comb begin
    unique case (rd_addr_i)
      REG_ID_HIGH: rd_data_o = id_high_q;
      REG_ID_LOW:  rd_data_o = id_low_q;
      default:     rd_data_o = '0;
    endcase
  end

endmodule

FILE: design/mdio_ms_frame.sv
`timescale 1ns / 1ps

module mdio_ms_frame (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         mdc_i,
  input  logic                         mdo_i,
  input  logic                         mdo_enable_i,
  output logic [4:0]                   rd_addr_o,
  input  logic [15:0]                  rd_data_i,
  output mdio_ms_pkg::mdio_ms_result_t result_o
);
  import mdio_ms_pkg::*;

  logic                   prev_clk_q;
  logic signed [CntW-1:0] cnt_q, cnt_d, cnt_e;
  logic [31:0]            shift_in_q, shift_in_d;
  logic [15:0]            shift_out_q, shift_out_d, shift_out_e;
  logic [1:0]             mode_q, mode_d, mode_e;
  logic [4:0]             phy_q, phy_d;
  logic [4:0]             reg_q, reg_d;
  logic                   mdi_q, mdi_d;
  logic                   rise;
  logic [1:0]             start_f, op_f, ta_f;

  assign rise      = mdc_i & ~prev_clk_q;
  assign start_f   = shift_in_d[15:14];
  assign op_f      = shift_in_d[13:12];
  assign ta_f      = shift_in_d[1:0];
  assign rd_addr_o = shift_in_d[6:2];

  // Frame logic, evaluated for a rising management clock edge.
  always_comb begin
    shift_in_d  = shift_in_q;
    cnt_e       = cnt_q;
    mode_e      = mode_q;
    shift_out_e = shift_out_q;
    phy_d       = phy_q;
    reg_d       = reg_q;
    mdi_d       = mdi_q;
    shift_out_d = shift_out_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    result_o    = '0;

    if (rise) begin
      shift_in_d = {shift_in_q[30:0], mdo_i & mdo_enable_i};

      // Thirty-two ones resynchronize the frame.
      if (&shift_in_d) begin
        cnt_e = CNT_RESYNC;
      end

      // Header decode once the sixteen header bits are in.
      if (cnt_e == CNT_DECODE) begin
        if (start_f == START_CODE && op_f == OPC_WRITE && ta_f == TA_WRITE) begin
          mode_e = MODE_WRITING;
        end else if (start_f == START_CODE && op_f == OPC_READ && !ta_f[0]) begin
          mode_e = MODE_READING;
        end else begin
          mode_e = MODE_IDLE;
        end
        if (mode_e != MODE_IDLE) begin
          phy_d = shift_in_d[11:7];
          reg_d = shift_in_d[6:2];
        end
        if (mode_e == MODE_READING) begin
          shift_out_e = rd_data_i;
        end
      end

      // Read data goes out most significant bit first.
      shift_out_d = shift_out_e;
      if (cnt_e < CNT_DECODE && mode_e == MODE_READING) begin
        mdi_d       = shift_out_e[15];
        shift_out_d = {shift_out_e[14:0], 1'b0};
      end

      // End of frame: a write reports its address and data.
      mode_d = mode_e;
      if (cnt_e == CNT_LAST && mode_e != MODE_IDLE) begin
        if (mode_e == MODE_WRITING) begin
          result_o.write_done = 1'b1;
          result_o.write_phy  = phy_d;
          result_o.write_reg  = reg_d;
          result_o.write_data = shift_in_d[15:0];
        end
        mode_d = MODE_IDLE;
      end

      // The counter stops at its bottom until the next resync.
      cnt_d = (cnt_e != CNT_STOP) ? cnt_e - 7'sd1 : cnt_e;
    end

    result_o.mdi_level = mdi_d;
  end

  // Frame state, advanced once per line sample transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clk_q  <= 1'b0;
      cnt_q       <= '0;
      shift_in_q  <= '0;
      shift_out_q <= '0;
      mode_q      <= MODE_IDLE;
      phy_q       <= '0;
      reg_q       <= '0;
      mdi_q       <= 1'b0;
    end else if (step_i) begin
      prev_clk_q  <= mdc_i;
      cnt_q       <= cnt_d;
      shift_in_q  <= shift_in_d;
      shift_out_q <= shift_out_d;
      mode_q      <= mode_d;
      phy_q       <= phy_d;
      reg_q       <= reg_d;
      mdi_q       <= mdi_d;
    end
  end

endmodule

FILE: design/mdio_ms_checker.sv
`timescale 1ns / 1ps

module mdio_ms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        mdi_level_o,
  input logic        write_done_o,
  input logic [4:0]  write_phy_o,
  input logic [4:0]  write_reg_o,
  input logic [15:0] write_data_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mdi_level_o)
      && $stable(write_done_o) && $stable(write_data_o))
    else $error("stalled result changed");

  // With the result register empty, the input side never stalls.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Without a completed write the write fields read zero.
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_done_o |-> write_phy_o == 5'd0 && write_reg_o == 5'd0
      && write_data_o == 16'd0)
    else $error("write fields nonzero without write");

  // Two write completions can never come in consecutive results.
  a_write_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && write_done_o |=> !(out_valid_o && write_done_o))
    else $error("back-to-back write completions");

endmodule

bind mdio_management_slave mdio_ms_checker u_mdio_ms_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .mdi_level_o  (mdi_level_o),
  .write_done_o (write_done_o),
  .write_phy_o  (write_phy_o),
  .write_reg_o  (write_reg_o),
  .write_data_o (write_data_o)
);
